>>> rtl/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg
// Shared widths, the transfer type and the sigmoid lookup table of the neuron.
// ----------------------------------------------------------------------------
`default_nettype none

package nms_pkg;

    localparam int ACT_W                 = 16;
    localparam int PROD_W                = 2 * ACT_W;
    localparam int ACC_W                 = 40;
    localparam int FRACTION_BITS         = 12;
    localparam int SIGMOID_TABLE_ENTRIES = 256;
    localparam int SIG_W                 = 16;
    localparam int IDX_W                 = $clog2(SIGMOID_TABLE_ENTRIES);
    localparam int NUM_W                 = $clog2(SIGMOID_TABLE_ENTRIES + 1);
    localparam int OFF_W                 = 2 * FRACTION_BITS + 4;
    localparam int QUEUE_DEPTH           = 2;
    localparam int SERIES_TERMS          = 24;

    typedef logic [SIG_W-1:0] t_sig_table [SIGMOID_TABLE_ENTRIES];

    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
    } t_sum_xfer;

    function automatic logic [63:0] f_term_div(input logic [63:0] mag, input int i);
        logic [63:0] res;
        case (i)
            2:       res = mag / 64'd2;
            3:       res = mag / 64'd3;
            4:       res = mag / 64'd4;
            5:       res = mag / 64'd5;
            6:       res = mag / 64'd6;
            7:       res = mag / 64'd7;
            8:       res = mag / 64'd8;
            9:       res = mag / 64'd9;
            10:      res = mag / 64'd10;
            11:      res = mag / 64'd11;
            12:      res = mag / 64'd12;
            13:      res = mag / 64'd13;
            14:      res = mag / 64'd14;
            15:      res = mag / 64'd15;
            16:      res = mag / 64'd16;
            17:      res = mag / 64'd17;
            18:      res = mag / 64'd18;
            19:      res = mag / 64'd19;
            20:      res = mag / 64'd20;
            21:      res = mag / 64'd21;
            22:      res = mag / 64'd22;
            23:      res = mag / 64'd23;
            24:      res = mag / 64'd24;
            default: res = mag;
        endcase
        return res;
    endfunction

    // sigmoid at bin midpoints over -8..8, exp series in q30
    function automatic t_sig_table f_build_sig_table();
        t_sig_table        tab;
        logic signed [63:0] x;
        logic signed [63:0] esum;
        logic [63:0]       t;
        logic [63:0]       s;
        logic [63:0]       mag;
        logic [63:0]       e;
        logic [63:0]       den;
        logic [63:0]       num;
        logic [63:0]       q;
        int                k;
        int                i;
        int                b;
        for (k = 0; k < SIGMOID_TABLE_ENTRIES; k++) begin
            x = ((64'sd2 * k + 64'sd1) * (64'sd8 <<< 30)) / SIGMOID_TABLE_ENTRIES
                - (64'sd8 <<< 30);
            t = (x < 0) ? -x : x;
            s = t >> 3;
            mag  = 64'd1 << 30;
            esum = 64'sd1 <<< 30;
            for (i = 1; i <= SERIES_TERMS; i++) begin
                mag = (mag * s) >> 30;
                mag = f_term_div(mag, i);
                if (i % 2 == 1) begin
                    esum = esum - $signed(mag);
                end else begin
                    esum = esum + $signed(mag);
                end
            end
            if (esum < 0) begin
                esum = 64'sd0;
            end
            e = esum;
            for (i = 0; i < 3; i++) begin
                e = (e * e) >> 30;
            end
            den = (64'd1 << 30) + e;
            if (x >= 0) begin
                num = 64'd1 << (FRACTION_BITS + 30);
            end else begin
                num = e << FRACTION_BITS;
            end
            num = num + (den >> 1);
            q   = 64'd0;
            for (b = FRACTION_BITS; b >= 0; b--) begin
                if (num >= (den << b)) begin
                    num  = num - (den << b);
                    q[b] = 1'b1;
                end
            end
            tab[k] = q[SIG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sig_table SIG_TABLE = f_build_sig_table();

endpackage

`default_nettype wire

>>> rtl/nms_front.sv
// ----------------------------------------------------------------------------
// nms_front
// Multiply stage and accumulator; hands finished sums to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic signed [nms_pkg::ACT_W-1:0] i_activation,
    input  wire logic signed [nms_pkg::ACT_W-1:0] i_weight,
    input  wire logic                             i_last_term,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_full,
    output nms_pkg::t_sum_xfer                    o_push
);

    logic                              r_s1_valid;
    logic                              r_s1_last;
    logic signed [nms_pkg::PROD_W-1:0] r_s1_prod;
    logic signed [nms_pkg::ACC_W-1:0]  r_acc;
    logic signed [nms_pkg::ACC_W-1:0]  acc_sum;
    logic                              s1_adv;

    assign s1_adv  = r_s1_valid && (!r_s1_last || !i_full);
    assign o_ready = !r_s1_valid || s1_adv;
    assign acc_sum = r_acc + nms_pkg::ACC_W'(r_s1_prod);

    assign o_push.valid = s1_adv && r_s1_last;
    assign o_push.sum   = acc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_acc      <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_acc <= r_s1_last ? '0 : acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_prod <= i_activation * i_weight;
            r_s1_last <= i_last_term;
        end
    end

endmodule

`default_nettype wire

>>> rtl/nms_queue.sv
// ----------------------------------------------------------------------------
// nms_queue
// Short queue of finished sums between accumulator and activation unit.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire nms_pkg::t_sum_xfer i_push,
    output logic                    o_full,
    output nms_pkg::t_sum_xfer      o_head,
    input  wire logic               i_pop
);

    localparam int PTR_W = (nms_pkg::QUEUE_DEPTH > 1) ? $clog2(nms_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(nms_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(nms_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(nms_pkg::QUEUE_DEPTH);

    logic signed [nms_pkg::ACC_W-1:0] r_mem [nms_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]                 r_wr_ptr;
    logic [PTR_W-1:0]                 r_rd_ptr;
    logic [CNT_W-1:0]                 r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.sum   = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.sum;
        end
    end

endmodule

`default_nettype wire

>>> rtl/nms_back.sv
// ----------------------------------------------------------------------------
// nms_back
// Swish activation sequencer: table lookup, multiply, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module nms_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire nms_pkg::t_sum_xfer          i_head,
    output logic                             o_pop,
    output logic [nms_pkg::ACT_W-1:0]        o_neuron_output,
    output logic                             o_valid,
    input  wire logic                        i_ready
);

    localparam int F2    = 2 * nms_pkg::FRACTION_BITS;
    localparam int P_W   = nms_pkg::ACC_W + nms_pkg::SIG_W + 1;
    localparam int RES_W = P_W - F2;
    localparam int MUL_W = nms_pkg::OFF_W + nms_pkg::NUM_W;

    localparam logic signed [nms_pkg::ACC_W-1:0] SUM_LIM =
        nms_pkg::ACC_W'(64'd8 << F2);
    localparam logic [nms_pkg::NUM_W-1:0] TABLE_MULT =
        nms_pkg::NUM_W'(nms_pkg::SIGMOID_TABLE_ENTRIES);
    localparam logic signed [nms_pkg::SIG_W:0] SIG_ONE =
        (nms_pkg::SIG_W + 1)'(64'd1 << nms_pkg::FRACTION_BITS);
    localparam logic signed [P_W-1:0] ROUND_C = P_W'(64'd1 << (F2 - 1));
    localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(2 ** (nms_pkg::ACT_W - 1) - 1);
    localparam logic signed [RES_W-1:0] OUT_MIN = ~OUT_MAX;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_INDEX,
        ST_LOOKUP,
        ST_MUL,
        ST_ROUND
    } t_state;

    t_state                           r_state;
    logic signed [nms_pkg::ACC_W-1:0] r_sum;
    logic                             r_below;
    logic                             r_above;
    logic [nms_pkg::OFF_W-1:0]        r_off;
    logic [MUL_W-1:0]                 r_idx_prod;
    logic signed [nms_pkg::SIG_W:0]   r_sig;
    logic signed [P_W-1:0]            r_p;
    logic                             r_valid;
    logic [nms_pkg::ACT_W-1:0]        r_out;

    logic signed [nms_pkg::ACC_W-1:0] sum_off;
    logic [nms_pkg::IDX_W-1:0]        idx;
    logic signed [P_W-1:0]            prod;
    logic signed [RES_W-1:0]          rnd;
    logic [nms_pkg::ACT_W-1:0]        sat;

    assign o_pop           = (r_state == ST_IDLE) && i_head.valid;
    assign o_valid         = r_valid;
    assign o_neuron_output = r_out;

    assign sum_off = r_sum + SUM_LIM;
    assign idx     = r_idx_prod[nms_pkg::OFF_W +: nms_pkg::IDX_W];
    assign prod    = r_sum * r_sig;
    assign rnd     = r_p[P_W-1:F2];

    always_comb begin
        if (rnd > OUT_MAX) begin
            sat = OUT_MAX[nms_pkg::ACT_W-1:0];
        end else if (rnd < OUT_MIN) begin
            sat = OUT_MIN[nms_pkg::ACT_W-1:0];
        end else begin
            sat = rnd[nms_pkg::ACT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready && (r_state != ST_ROUND)) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_sum   <= i_head.sum;
                        r_state <= ST_RANGE;
                    end
                end
                ST_RANGE: begin
                    r_below <= (r_sum < -SUM_LIM);
                    r_above <= (r_sum >= SUM_LIM);
                    r_off   <= sum_off[nms_pkg::OFF_W-1:0];
                    r_state <= ST_INDEX;
                end
                ST_INDEX: begin
                    r_idx_prod <= r_off * TABLE_MULT;
                    r_state    <= ST_LOOKUP;
                end
                ST_LOOKUP: begin
                    if (r_below) begin
                        r_sig <= '0;
                    end else if (r_above) begin
                        r_sig <= SIG_ONE;
                    end else begin
                        r_sig <= {1'b0, nms_pkg::SIG_TABLE[idx]};
                    end
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_p     <= prod + ROUND_C;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (!r_valid || i_ready) begin
                        r_out   <= sat;
                        r_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/neuron_mac_swish.sv
// ----------------------------------------------------------------------------
// neuron_mac_swish
// Dense neuron: multiply-accumulate of Q4.12 terms, swish on the last term.
// Accepts one term per cycle while the sum queue has room.
// A result is valid after its sum leaves the queue and passes RANGE, INDEX,
// LOOKUP, MUL and ROUND; the next sum is taken only back in IDLE, so neurons
// shorter than 6 terms stall input once the 2-entry sum queue fills.
// Synchronous reset clears the accumulator, the queue and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module neuron_mac_swish (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic signed [nms_pkg::ACT_W-1:0] i_activation,
    input  wire logic signed [nms_pkg::ACT_W-1:0] i_weight,
    input  wire logic                             i_last_term,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    output logic signed [nms_pkg::ACT_W-1:0]      o_neuron_output,
    output logic                                  o_valid,
    input  wire logic                             i_ready
);

    nms_pkg::t_sum_xfer        push;
    nms_pkg::t_sum_xfer        head;
    logic                      full;
    logic                      pop;
    logic [nms_pkg::ACT_W-1:0] out_bits;

    nms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_activation (i_activation),
        .i_weight     (i_weight),
        .i_last_term  (i_last_term),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_full       (full),
        .o_push       (push)
    );

    nms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    nms_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_neuron_output (out_bits),
        .o_valid         (o_valid),
        .i_ready         (i_ready)
    );

    assign o_neuron_output = $signed(out_bits);

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neuron_mac_swish testbench
// Feeds runs of activation/weight terms, including the extremes and the sums
// below and above the sigmoid range. Each neuron result is checked against a
// hand-typed value on the typed directed rows, else against a bit-exact swish
// predictor with its own sigmoid table, under random idling on both sides of the block.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF     = 5;
    localparam int IDLE_PCT     = 18;
    localparam int RANDOM_TERMS = 500;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int N_DIR        = 18;
    localparam int LIM_SHIFT    = 2 * nms_pkg::FRACTION_BITS;

    localparam logic signed [nms_pkg::ACT_W-1:0] Q_ONE = 16'sh1000;
    localparam logic signed [nms_pkg::ACT_W-1:0] Q_MAX = 16'sh7fff;
    localparam logic signed [nms_pkg::ACT_W-1:0] Q_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [nms_pkg::ACT_W-1:0] act;
        logic signed [nms_pkg::ACT_W-1:0] wgt;
        logic                             is_last;
        logic                             typed;
        logic signed [nms_pkg::ACT_W-1:0] want;
    } t_term_row;

    localparam t_term_row DIR_ROWS [N_DIR] = '{
        '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'sh0000},
        '{Q_ONE,     16'sh0000, 1'b1, 1'b1, 16'sh0000},
        '{Q_MIN,     Q_MAX,     1'b1, 1'b1, 16'sh0000},
        '{Q_MAX,     Q_MAX,     1'b1, 1'b1, Q_MAX},
        '{Q_MIN,     Q_MIN,     1'b1, 1'b1, Q_MAX},
        '{16'sh2000, 16'sh4000, 1'b1, 1'b1, Q_MAX},
        '{Q_MIN,     Q_ONE,     1'b1, 1'b0, 16'sh0000},
        '{Q_ONE,     Q_ONE,     1'b1, 1'b0, 16'sh0000},
        '{Q_ONE,     16'sh0800, 1'b0, 1'b0, 16'sh0000},
        '{Q_ONE,     16'sh0400, 1'b0, 1'b0, 16'sh0000},
        '{Q_ONE,     16'sh0200, 1'b1, 1'b0, 16'sh0000},
        '{Q_MAX,     Q_MAX,     1'b0, 1'b0, 16'sh0000},
        '{Q_MAX,     -16'sh7fff, 1'b1, 1'b1, 16'sh0000},
        '{16'sh2000, 16'sh3fff, 1'b1, 1'b0, 16'sh0000},
        '{-16'sh1000, Q_ONE,    1'b1, 1'b0, 16'sh0000},
        '{Q_MAX,     16'sh0001, 1'b1, 1'b0, 16'sh0000},
        '{-16'sh0001, -16'sh0001, 1'b1, 1'b0, 16'sh0000},
        '{16'sh0001, Q_MIN,     1'b1, 1'b0, 16'sh0000}
    };

    logic                             i_clk;
    logic                             i_rst_n;
    logic signed [nms_pkg::ACT_W-1:0] i_activation;
    logic signed [nms_pkg::ACT_W-1:0] i_weight;
    logic                             i_last_term;
    logic                             i_valid;
    logic                             o_ready;
    logic signed [nms_pkg::ACT_W-1:0] o_neuron_output;
    logic                             o_valid;
    logic                             i_ready;

    logic [nms_pkg::SIG_W-1:0]        sigmoid_lut [nms_pkg::SIGMOID_TABLE_ENTRIES];
    logic signed [nms_pkg::ACC_W-1:0] neuron_sum;
    logic signed [nms_pkg::ACT_W-1:0] expected_outputs [$];
    logic signed [nms_pkg::ACT_W-1:0] oldest_output;
    int                               mismatch_count;
    int                               stall_cycles;
    int                               random_terms;
    bit                               no_idle;

    neuron_mac_swish dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_activation    (i_activation),
        .i_weight        (i_weight),
        .i_last_term     (i_last_term),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .o_neuron_output (o_neuron_output),
        .o_valid         (o_valid),
        .i_ready         (i_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // e^-t in q30 by truncated series, then raised to the eighth power
    function automatic longint exp_neg_q30(input longint t);
        longint          s;
        longint          term;
        longint          series;
        longint unsigned e;
        int              i;
        s      = t / 8;
        term   = longint'(1) <<< 30;
        series = term;
        for (i = 1; i <= nms_pkg::SERIES_TERMS; i++) begin
            term   = (term * (-s)) / (longint'(1) <<< 30);
            term   = term / i;
            series = series + term;
        end
        if (series < 0) begin
            series = 0;
        end
        e = series;
        repeat (3) e = (e * e) >> 30;
        return longint'(e);
    endfunction

    function automatic void build_sigmoid_lut();
        longint x;
        longint t;
        longint e;
        longint den;
        longint num;
        int     k;
        for (k = 0; k < nms_pkg::SIGMOID_TABLE_ENTRIES; k++) begin
            x   = ((2 * longint'(k) + 1) * (longint'(8) <<< 30))
                  / nms_pkg::SIGMOID_TABLE_ENTRIES - (longint'(8) <<< 30);
            t   = (x < 0) ? -x : x;
            e   = exp_neg_q30(t);
            den = (longint'(1) <<< 30) + e;
            num = (x >= 0) ? (longint'(1) <<< (nms_pkg::FRACTION_BITS + 30))
                           : (e <<< nms_pkg::FRACTION_BITS);
            sigmoid_lut[k] = nms_pkg::SIG_W'((num + den / 2) / den);
        end
    endfunction

    function automatic logic signed [nms_pkg::ACT_W-1:0] swish_of_sum(
        input logic signed [nms_pkg::ACC_W-1:0] sum);
        longint s;
        longint lim;
        longint sig;
        longint idx;
        longint p;
        s   = sum;
        lim = longint'(8) <<< LIM_SHIFT;
        if (s < -lim) begin
            sig = 0;
        end else if (s >= lim) begin
            sig = longint'(1) <<< nms_pkg::FRACTION_BITS;
        end else begin
            idx = ((s + lim) * nms_pkg::SIGMOID_TABLE_ENTRIES) / (longint'(16) <<< LIM_SHIFT);
            if (idx >= nms_pkg::SIGMOID_TABLE_ENTRIES) begin
                idx = nms_pkg::SIGMOID_TABLE_ENTRIES - 1;
            end
            sig = longint'(sigmoid_lut[idx]);
        end
        p = (s * sig + (longint'(1) <<< (LIM_SHIFT - 1))) >>> LIM_SHIFT;
        if (p > 32767) begin
            p = 32767;
        end
        if (p < -32768) begin
            p = -32768;
        end
        return nms_pkg::ACT_W'(p);
    endfunction

    // accumulate one term; on the last term return the neuron output
    function automatic bit fold_term(input logic signed [nms_pkg::ACT_W-1:0] a,
                                     input logic signed [nms_pkg::ACT_W-1:0] w,
                                     input logic is_last,
                                     output logic signed [nms_pkg::ACT_W-1:0] y);
        longint prod;
        prod       = longint'(a) * longint'(w);
        neuron_sum = neuron_sum + nms_pkg::ACC_W'(prod);
        y          = '0;
        if (!is_last) begin
            return 1'b0;
        end
        y          = swish_of_sum(neuron_sum);
        neuron_sum = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_term(input logic signed [nms_pkg::ACT_W-1:0] a,
                             input logic signed [nms_pkg::ACT_W-1:0] w,
                             input logic is_last,
                             input logic typed,
                             input logic signed [nms_pkg::ACT_W-1:0] want);
        logic signed [nms_pkg::ACT_W-1:0] y;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_activation <= a;
        i_weight     <= w;
        i_last_term  <= is_last;
        do @(posedge i_clk); while (!o_ready);
        if (fold_term(a, w, is_last, y)) begin
            expected_outputs.push_back(typed ? want : y);
        end
    endtask

    task automatic pick_term(input int mode, input int j,
                             output logic signed [nms_pkg::ACT_W-1:0] a,
                             output logic signed [nms_pkg::ACT_W-1:0] w);
        logic signed [nms_pkg::ACT_W-1:0] corners [6];
        corners = '{Q_MIN, Q_MAX, 16'sh0000, -16'sh0001, 16'sh0001, Q_ONE};
        case (mode)
            0: begin
                a = nms_pkg::ACT_W'($urandom);
                w = nms_pkg::ACT_W'($urandom);
            end
            1: begin
                a = nms_pkg::ACT_W'(int'($urandom_range(0, 16383)) - 8192);
                w = nms_pkg::ACT_W'(int'($urandom_range(0, 16383)) - 8192);
            end
            2: begin
                a = (j == 0) ? Q_ONE
                             : nms_pkg::ACT_W'(int'($urandom_range(0, 8191)) - 4096);
                w = nms_pkg::ACT_W'(int'($urandom_range(0, 32767)) - 16384);
            end
            default: begin
                a = corners[$urandom_range(5)];
                w = corners[$urandom_range(5)];
            end
        endcase
    endtask

    task automatic run_neuron(input int len, input int mode);
        logic signed [nms_pkg::ACT_W-1:0] a;
        logic signed [nms_pkg::ACT_W-1:0] w;
        int                               j;
        for (j = 0; j < len; j++) begin
            pick_term(mode, j, a, w);
            send_term(a, w, j == len - 1, 1'b0, '0);
            random_terms++;
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("output %0d with no neuron pending",
                                          o_neuron_output));
            end else begin
                oldest_output = expected_outputs.pop_front();
                if (o_neuron_output !== oldest_output) begin
                    report_mismatch($sformatf("neuron_output %0d, expected %0d",
                                              o_neuron_output, oldest_output));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int  len;
        int  mode;
        bit  paused;
        int  r;
        random_terms   = 0;
        no_idle        = 1'b0;
        paused         = 1'b0;
        neuron_sum     = '0;
        build_sigmoid_lut();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_activation <= '0;
        i_weight     <= '0;
        i_last_term  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIR; r++) begin
            send_term(DIR_ROWS[r].act, DIR_ROWS[r].wgt, DIR_ROWS[r].is_last,
                      DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        while (random_terms < RANDOM_TERMS) begin
            if (!paused && random_terms >= 250) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (expected_outputs.size() != 0);
            end
            no_idle = (random_terms >= 300 && random_terms < 420);
            len  = ($urandom_range(99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            mode = $urandom_range(9);
            mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 8) ? 2 : 3;
            run_neuron(len, mode);
        end

        no_idle = 1'b0;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_outputs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/nms_pkg.sv
rtl/nms_front.sv
rtl/nms_queue.sv
rtl/nms_back.sv
rtl/neuron_mac_swish.sv
tb/sv/testbench.sv
